@@ hw/rtl/bmhpq_pkg.sv @@
`timescale 1ns / 1ps

package bmhpq_pkg;

    localparam int DEPTH    = 1024;
    localparam int TAG_BITS = 10;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = ADDR_W + 2;
    localparam int CMP_W   = (CNT_W > 11) ? CNT_W : 11;

    localparam int KEY_W       = 16;
    localparam int TAG_FIELD_W = 10;
    localparam int CNT_FIELD_W = 11;

    localparam logic [CNT_FIELD_W-1:0] CAP_RESET = 11'd1024;

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

endpackage

@@ hw/rtl/bmhpq_ram.sv @@
`timescale 1ns / 1ps

module bmhpq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
`timescale 1ns / 1ps
// Binary max-heap priority queue, up to 1024 entries of {16-bit 8.8 key, tag}.
// Input stream: i_s_tuser[0] is the operation (0 insert, 1 remove top);
// i_s_tdata carries key and tag. One transfer in gives exactly one transfer out:
// o_m_tuser = {status, top_valid}, o_m_tdata = {count, top_tag, top_key}.
// The heap lives in one single-port-read RAM; each sift level is a read, a
// compare and a write back, one read per cycle, with registered read data.
// An insert climbs from the new last slot, comparing with the parent at each
// level; a remove moves the last entry to the root and descends, reading the
// left and then the right child at each level. Rejected operations (insert
// when full, remove when empty) go straight to the result without a heap step.
// o_s_tready is high only between items, so the block takes no new item until
// the last one has reached the output register.
// The result sits in an output register, so a new item is taken while a result
// still waits; a stalled receiver holds the next result back only when that
// result is ready to leave.
// Reset (synchronous, active low) empties the heap and sets capacity to 1024.
// The RAM needs no clearing: only entries below the count are ever read.
// The APB port holds capacity at address 0; the user must write it only while the block is idle (not enforced here).
module binary_max_heap_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // key[15:0], tag[25:16]
    input  logic [0:0]  i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // top_key[15:0], top_tag[25:16], count[36:26]
    output logic [2:0]  o_m_tuser,  // top_valid[0], status[2:1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP     = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_LAST   = 8'b0000_1000,
        S_DN     = 8'b0001_0000,
        S_DN_L   = 8'b0010_0000,
        S_DN_R   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [bmhpq_pkg::CNT_W-1:0]       r_count, n_count;
    logic [bmhpq_pkg::CNT_FIELD_W-1:0] r_capacity;
    bmhpq_pkg::t_entry                 r_item, n_item;
    bmhpq_pkg::t_entry                 r_left, n_left;
    logic                              r_left_win, n_left_win;
    logic [bmhpq_pkg::ADDR_W-1:0]      r_pos, n_pos;
    bmhpq_pkg::t_status                r_status, n_status;
    bmhpq_pkg::t_entry                 r_root;
    logic                              r_out_valid;
    logic [39:0]                       r_out_data;
    logic [2:0]                        r_out_user;

    logic                          ram_we;
    logic [bmhpq_pkg::ADDR_W-1:0]  ram_waddr;
    logic [bmhpq_pkg::ADDR_W-1:0]  ram_raddr;
    bmhpq_pkg::t_entry             ram_wdata;
    bmhpq_pkg::t_entry             rd;
    logic [$bits(bmhpq_pkg::t_entry)-1:0] rd_raw;

    logic                         s_xfer;
    logic                         cfg_wr;
    logic                         full;
    logic [bmhpq_pkg::ADDR_W-1:0] parent;
    logic [bmhpq_pkg::CHILD_W-1:0] lc, rc, n_ext;
    logic                         left_win, right_win;
    logic [bmhpq_pkg::KEY_W-1:0]  best_key;
    logic                         out_load;
    logic                         top_valid;

    bmhpq_ram #(
        .WIDTH ($bits(bmhpq_pkg::t_entry)),
        .DEPTH (bmhpq_pkg::DEPTH)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_raw)
    );

    assign rd = bmhpq_pkg::t_entry'(rd_raw);

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == bmhpq_pkg::REG_CAPACITY) ? 32'(r_capacity) : 32'd0;

    assign full = (bmhpq_pkg::CMP_W'(r_count) >= bmhpq_pkg::CMP_W'(bmhpq_pkg::DEPTH)) ||
                  (bmhpq_pkg::CMP_W'(r_count) >= bmhpq_pkg::CMP_W'(r_capacity));

    assign parent    = (r_pos - bmhpq_pkg::ADDR_W'(1)) >> 1;
    assign lc        = bmhpq_pkg::CHILD_W'({r_pos, 1'b1});
    assign rc        = lc + bmhpq_pkg::CHILD_W'(1);
    assign n_ext     = bmhpq_pkg::CHILD_W'(r_count);
    assign left_win  = rd.key >= r_item.key;
    assign best_key  = r_left_win ? r_left.key : r_item.key;
    assign right_win = rd.key >= best_key;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign top_valid = (r_count != '0);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_item     = r_item;
        n_left     = r_left;
        n_left_win = r_left_win;
        n_pos      = r_pos;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = r_item;
        ram_raddr  = parent;
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = bmhpq_pkg::ADDR_W'(r_count - bmhpq_pkg::CNT_W'(1));
                if (s_xfer) begin
                    n_status = bmhpq_pkg::ST_DONE;
                    if (i_s_tuser[0] == bmhpq_pkg::OP_INSERT) begin
                        if (full) begin
                            n_status = bmhpq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_item.key = i_s_tdata[15:0];
                            n_item.tag = bmhpq_pkg::TAG_BITS'(i_s_tdata[25:16]);
                            n_pos      = bmhpq_pkg::ADDR_W'(r_count);
                            n_count    = r_count + bmhpq_pkg::CNT_W'(1);
                            n_state    = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmhpq_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count - bmhpq_pkg::CNT_W'(1);
                            n_state = S_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (rd.key < r_item.key) begin
                    ram_wdata = rd;
                    n_pos     = parent;
                    n_state   = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST: begin
                n_item = rd;
                n_pos  = '0;
                n_state = (r_count == '0) ? S_DONE : S_DN;
            end
            S_DN: begin
                ram_raddr = bmhpq_pkg::ADDR_W'(lc);
                if (lc >= n_ext) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                ram_raddr = bmhpq_pkg::ADDR_W'(rc);
                if (rc < n_ext) begin
                    n_left     = rd;
                    n_left_win = left_win;
                    n_state    = S_DN_R;
                end else begin
                    ram_we = 1'b1;
                    if (left_win) begin
                        ram_wdata = rd;
                        n_pos     = bmhpq_pkg::ADDR_W'(lc);
                        n_state   = S_DN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DN_R: begin
                ram_we = 1'b1;
                if (right_win) begin
                    ram_wdata = rd;
                    n_pos     = bmhpq_pkg::ADDR_W'(rc);
                    n_state   = S_DN;
                end else if (r_left_win) begin
                    ram_wdata = r_left;
                    n_pos     = bmhpq_pkg::ADDR_W'(lc);
                    n_state   = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= bmhpq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (cfg_wr && paddr[2] == bmhpq_pkg::REG_CAPACITY) begin
                r_capacity <= pwdata[bmhpq_pkg::CNT_FIELD_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_left     <= n_left;
        r_left_win <= n_left_win;
        r_pos      <= n_pos;
        r_status   <= n_status;
        if (ram_we && ram_waddr == '0) begin
            r_root <= ram_wdata;
        end
        if (out_load) begin
            r_out_data <= {3'b000,
                           bmhpq_pkg::CNT_FIELD_W'(r_count),
                           top_valid ? bmhpq_pkg::TAG_FIELD_W'(r_root.tag)
                                     : bmhpq_pkg::TAG_FIELD_W'(0),
                           top_valid ? r_root.key : bmhpq_pkg::KEY_W'(0)};
            r_out_user <= {r_status, top_valid};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bmhpq_pkg::CNT_W'(bmhpq_pkg::DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && i_s_tuser[0] == bmhpq_pkg::OP_INSERT && !full)
        |=> r_count == $past(r_count) + bmhpq_pkg::CNT_W'(1))
        else $error("accepted insert did not grow the heap");

    a_top_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tdata[36:26] != '0)))
        else $error("top_valid disagrees with count");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_LAST) |-> !ram_we)
        else $error("heap write outside a sift step");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic                        top_valid;
        logic [bmhpq_pkg::KEY_W-1:0] top_key;
        logic [9:0]                  top_tag;
        logic [10:0]                 count;
        bmhpq_pkg::t_status          status;
    } t_report;

    typedef struct {
        bit          cfg;
        logic        op;
        logic [15:0] key;
        logic [9:0]  tag;
        logic [10:0] cap;
        bit          typed;
        t_report     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    binary_max_heap_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // heap shadow
    bmhpq_pkg::t_entry heap_mem [bmhpq_pkg::DEPTH];
    int unsigned heap_len = 0;
    logic [10:0] cap_reg = bmhpq_pkg::CAP_RESET;
    t_report     report_q [$];
    int          mismatch_cnt = 0;
    int unsigned burst_left = 0;
    bit          hold_go = 1'b0;

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    function automatic t_report heap_apply(input logic op, input logic [15:0] k_in,
                                           input logic [9:0] t_in);
        int unsigned       lim, pos, up, lc, rc, pick;
        bmhpq_pkg::t_entry tmp;
        t_report           r;
        r.status = bmhpq_pkg::ST_DONE;
        lim = (cap_reg > bmhpq_pkg::DEPTH) ? bmhpq_pkg::DEPTH : cap_reg;
        if (op == bmhpq_pkg::OP_INSERT) begin
            if (heap_len >= lim) begin
                r.status = bmhpq_pkg::ST_FULL;
            end else begin
                pos = heap_len;
                heap_mem[pos].key = k_in;
                heap_mem[pos].tag = t_in;
                heap_len++;
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mem[up].key >= heap_mem[pos].key) break;
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[up];
                    heap_mem[up] = tmp;
                    pos = up;
                end
            end
        end else if (heap_len == 0) begin
            r.status = bmhpq_pkg::ST_EMPTY;
        end else begin
            heap_len--;
            heap_mem[0] = heap_mem[heap_len];
            pos = 0;
            while (1) begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                pick = pos;
                if (lc < heap_len && heap_mem[lc].key >= heap_mem[pick].key) pick = lc;
                // right after left: ties go right
                if (rc < heap_len && heap_mem[rc].key >= heap_mem[pick].key) pick = rc;
                if (pick == pos) break;
                tmp = heap_mem[pos];
                heap_mem[pos] = heap_mem[pick];
                heap_mem[pick] = tmp;
                pos = pick;
            end
        end
        r.top_valid = (heap_len != 0);
        r.top_key   = r.top_valid ? heap_mem[0].key : '0;
        r.top_tag   = r.top_valid ? heap_mem[0].tag : '0;
        r.count     = 11'(heap_len);
        return r;
    endfunction

    function automatic logic [15:0] pick_key(input bit tie_heavy);
        if (tie_heavy && $urandom_range(0, 1) == 1) begin
            return 16'($urandom_range(0, 3)) << 14;
        end
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            1: return 16'($urandom_range(0, 3)) << 14;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic op, input logic [15:0] k_in, input logic [9:0] t_in,
                           input bit typed, input t_report want);
        int unsigned gap;
        t_report     pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, t_in, k_in};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        pred = heap_apply(op, k_in, t_in);
        report_q.push_back(typed ? want : pred);
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cap_read_check(input logic [10:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {bmhpq_pkg::REG_CAPACITY, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(want)) begin
            note_mismatch($sformatf("capacity read exp %0d got %0d", want, got));
        end
    endtask

    task automatic cap_write(input logic [10:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bmhpq_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = val;
        @(posedge i_clk);
        cap_read_check(val);
    endtask

    // receiver: stall patterns, plus one long hold-off
    int unsigned hold_cnt = 0;
    int unsigned rx_mode = 0;
    int unsigned mode_left = 0;
    logic [2:0]  rx_phase = '0;

    always @(posedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            hold_cnt   <= hold_cnt + 1;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            rx_phase <= rx_phase + 1'b1;
            case (rx_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom_range(0, 1));
                2: i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= rx_phase[2];
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.top_valid = o_m_tuser[0];
            got.status    = bmhpq_pkg::t_status'(o_m_tuser[2:1]);
            got.top_key   = o_m_tdata[15:0];
            got.top_tag   = o_m_tdata[25:16];
            got.count     = o_m_tdata[36:26];
            if (report_q.size() == 0) begin
                note_mismatch("result transfer with nothing expected");
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    note_mismatch($sformatf(
                        "exp v=%0b key=%h tag=%h cnt=%0d st=%0d, got v=%0b key=%h tag=%h cnt=%0d st=%0d",
                        want.top_valid, want.top_key, want.top_tag, want.count, want.status,
                        got.top_valid, got.top_key, got.top_tag, got.count, got.status));
                end
            end
        end
    end

    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("** binary_max_heap_priority_queue: FAILED **");
            $finish;
        end
    end

    t_dir_row dir_tab [$] = '{
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 1,
          '{1'b0, 16'h0000, 10'h000, 11'd0, bmhpq_pkg::ST_EMPTY}},
        '{0, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd0, 1,
          '{1'b1, 16'h0000, 10'h000, 11'd1, bmhpq_pkg::ST_DONE}},
        '{0, bmhpq_pkg::OP_INSERT, 16'hFFFF, 10'h3FF, 11'd0, 1,
          '{1'b1, 16'hFFFF, 10'h3FF, 11'd2, bmhpq_pkg::ST_DONE}},
        '{0, bmhpq_pkg::OP_INSERT, 16'h8000, 10'h155, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h8000, 10'h2AA, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h8000, 10'h001, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h00FF, 10'h200, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 1,
          '{1'b0, 16'h0000, 10'h000, 11'd0, bmhpq_pkg::ST_DONE}},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h1234, 10'h0AB, 11'd0, 1,
          '{1'b0, 16'h0000, 10'h000, 11'd0, bmhpq_pkg::ST_FULL}},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd1, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h1234, 10'h0AB, 11'd0, 1,
          '{1'b1, 16'h1234, 10'h0AB, 11'd1, bmhpq_pkg::ST_DONE}},
        '{0, bmhpq_pkg::OP_INSERT, 16'hFFFF, 10'h3FF, 11'd0, 1,
          '{1'b1, 16'h1234, 10'h0AB, 11'd1, bmhpq_pkg::ST_FULL}},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd2047, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h0100, 10'h111, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h1234, 10'h222, 11'd0, 0, '0},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd3, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'h5555, 10'h333, 11'd0, 0, '0},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd1, 0, '0},
        '{0, bmhpq_pkg::OP_INSERT, 16'hAAAA, 10'h0F0, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{0, bmhpq_pkg::OP_REMOVE, 16'h0000, 10'h000, 11'd0, 0, '0},
        '{1, bmhpq_pkg::OP_INSERT, 16'h0000, 10'h000, 11'd1024, 0, '0}
    };

    initial begin
        int          ph, i, n_items, ins_pct;
        logic [10:0] cap_val;
        bit          tie_heavy;
        logic        op;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cap_read_check(bmhpq_pkg::CAP_RESET);
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].cfg) begin
                stop_sending();
                wait_drained();
                cap_write(dir_tab[r].cap);
            end else begin
                send_op(dir_tab[r].op, dir_tab[r].key, dir_tab[r].tag,
                        dir_tab[r].typed, dir_tab[r].want);
            end
        end

        for (ph = 0; ph < 7; ph++) begin
            tie_heavy = 1'b0;
            case (ph)
                0: begin cap_val = 11'd2047; ins_pct = 75; n_items = 150; end
                1: begin
                    // lowered below the current fill when the heap holds two or more entries
                    cap_val = (heap_len > 2) ? 11'(heap_len / 2) : 11'd1;
                    ins_pct = 30; n_items = 100;
                end
                2: begin
                    cap_val = 11'($urandom_range(1, 12));
                    ins_pct = 55; n_items = 100; tie_heavy = 1'b1;
                end
                3: begin cap_val = 11'd0; ins_pct = 50; n_items = 12; end
                4: begin cap_val = 11'd1024; ins_pct = 65; n_items = 150; tie_heavy = 1'b1; end
                5: begin cap_val = 11'($urandom_range(1, 1024)); ins_pct = 45; n_items = 100; end
                default: begin cap_val = 11'd1; ins_pct = 50; n_items = 40; end
            endcase
            stop_sending();
            wait_drained();
            cap_write(cap_val);
            if (ph == 0) hold_go <= 1'b1;
            for (i = 0; i < n_items; i++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? bmhpq_pkg::OP_INSERT
                                                       : bmhpq_pkg::OP_REMOVE;
                send_op(op, pick_key(tie_heavy), 10'($urandom_range(0, 1023)), 1'b0, '0);
            end
        end

        stop_sending();
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_cnt == 0 && report_q.size() == 0) begin
            $display("** binary_max_heap_priority_queue: PASSED **");
        end else begin
            $display("** binary_max_heap_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule
